// File: hw/rtl/layer_stream_decryptor_assert.svh
// Assertion macros used by the lsd_back module.
`ifndef LAYER_STREAM_DECRYPTOR_ASSERT_SVH
`define LAYER_STREAM_DECRYPTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("layer_stream_decryptor assertion failed");

// Next-cycle implication, disabled during reset.
`define LSD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("layer_stream_decryptor assertion failed");

`endif

// File: hw/rtl/lsd_pkg.sv
package lsd_pkg;

    // Permutation table geometry.
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Entries checked on an RC4-mode begin, and the marker value that makes a table invalid when both hold it.
    localparam logic [IDX_W-1:0] CHECK_LO_IDX = IDX_W'(TABLE_ENTRIES - 2);
    localparam logic [IDX_W-1:0] CHECK_HI_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [7:0]       BAD_MARK     = 8'hff;

    // Command codes on the input stream.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_SEED = 1'b1;

    // Mode values.
    localparam logic MODE_CHAIN = 1'b0;
    localparam logic MODE_RC4   = 1'b1;

    // Command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operations after classification by the front end.
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_BEGIN_CHAIN,
        OP_BEGIN_RC4,
        OP_DATA_CHAIN,
        OP_DATA_RC4
    } op_t;

    // One queued operation.
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] entry_index;
        logic [7:0]       entry_value;
        logic [31:0]      data_word;
        logic             final_req;
    } queue_item_t;

endpackage

// File: hw/rtl/layer_stream_decryptor.sv
// Chain-mode data passes the front-end holding register, the queue and the output register;
// RC4-mode data also passes back-end states ST_RD_J, ST_SWAP and ST_DONE before the output register.
// One table write per cycle, and one chain word per cycle while the output is free; an RC4 byte holds
// the back end through the read, swap and keystream accesses of the one-write, one-read table memory.
// A begin in RC4 mode occupies the back end through ST_BG_HI and ST_BG_CHK (two table reads).
// Reset (rst_n, asynchronous, active low) clears indexes, chain word, lock and queue.
module layer_stream_decryptor
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[7:0], entry_value[15:8], data_word[47:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        s_tlast,   // final_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_data[31:0]
    output logic [0:0]  m_tuser,   // rejected[0]
    output logic        m_tlast    // last_out
);

    logic        mode_reg;
    logic [31:0] chain_seed_reg;

    logic        push_valid;
    logic        push_ready;
    queue_item_t push_item;
    logic        pop_valid;
    logic        pop;
    queue_item_t pop_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_CHAIN;
            chain_seed_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index[0])
                REG_MODE: mode_reg       <= cfg_wdata[0];
                REG_SEED: chain_seed_reg <= cfg_wdata;
                default:  mode_reg       <= mode_reg;
            endcase
        end
    end

    // Front end: accept and classify transactions.
    lsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Operation queue between the two ends.
    lsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    // Back end: table, keystream and chain execution.
    lsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .chain_seed (chain_seed_reg),
        .q_valid    (pop_valid),
        .q_pop      (pop),
        .q_item     (pop_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// File: hw/rtl/lsd_front.sv
module lsd_front
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[7:0], entry_value[15:8], data_word[47:16]
    input  logic [1:0]  s_tuser,   // command[1:0]
    input  logic        s_tlast,
    output logic        push_valid,
    input  logic        push_ready,
    output queue_item_t push_item
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    queue_item_t hold_item_reg;
    queue_item_t cls_item;
    logic        cmd_known;
    logic        accept;

    // The holding register frees up whenever its content moves into the queue.
    assign s_tready   = !hold_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

    // Classify the incoming transaction by command and current mode.
    always_comb
    begin
        cmd_known             = s_tuser inside {CMD_WRITE, CMD_BEGIN, CMD_DATA};
        cls_item.entry_index  = s_tdata[7:0];
        cls_item.entry_value  = s_tdata[15:8];
        cls_item.data_word    = s_tdata[47:16];
        cls_item.final_req    = s_tlast;
        case (s_tuser)
            CMD_WRITE: cls_item.op = OP_WRITE;
            CMD_BEGIN: cls_item.op = (mode == MODE_RC4) ? OP_BEGIN_RC4 : OP_BEGIN_CHAIN;
            CMD_DATA:  cls_item.op = (mode == MODE_RC4) ? OP_DATA_RC4 : OP_DATA_CHAIN;
            default:   cls_item.op = OP_WRITE;
        endcase
    end

    // Unused command codes are accepted and dropped here.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = cmd_known;
        end
        else if (hold_valid_reg && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= cls_item;
        end
    end

endmodule

// File: hw/rtl/lsd_queue.sv
module lsd_queue
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  queue_item_t push_item,
    output logic        pop_valid,
    input  logic        pop,
    output queue_item_t pop_item
);

    queue_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/lsd_back.sv
`include "layer_stream_decryptor_assert.svh"

module lsd_back
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] chain_seed,
    input  logic        q_valid,
    output logic        q_pop,
    input  queue_item_t q_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_data[31:0]
    output logic [0:0]  m_tuser,   // rejected[0]
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_J,
        ST_SWAP,
        ST_DONE,
        ST_BG_HI,
        ST_BG_CHK
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [31:0]      prev_reg, prev_next;
    logic             locked_reg, locked_next;
    logic             bad_lo_reg, bad_lo_next;
    logic [7:0]       a_reg, a_next;
    logic [7:0]       b_reg, b_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic [7:0]       cipher_reg, cipher_next;
    logic             fin_reg, fin_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      out_data_reg, out_data_next;
    logic             out_rej_reg, out_rej_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       perm_mem [TABLE_ENTRIES];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic             out_free;
    logic [7:0]       key_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_rej_reg;
    assign m_tlast  = out_last_reg;

    // Keystream byte: forward the swapped entries over the stored copy.
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            key_byte = a_reg;
        end
        else if (t_reg == i_reg)
        begin
            key_byte = b_reg;
        end
        else
        begin
            key_byte = rd_data_reg;
        end
    end

    // Sequencer for the queued operations.
    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        prev_next     = prev_reg;
        locked_next   = locked_reg;
        bad_lo_next   = bad_lo_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        t_next        = t_reg;
        cipher_next   = cipher_reg;
        fin_next      = fin_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_rej_next  = out_rej_reg;
        out_last_next = out_last_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = q_item.entry_index;
        mem_wdata     = q_item.entry_value;
        mem_raddr     = i_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        OP_WRITE:
                        begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_BEGIN_CHAIN:
                        begin
                            q_pop     = 1'b1;
                            i_next    = '0;
                            j_next    = '0;
                            prev_next = chain_seed;
                        end
                        OP_BEGIN_RC4:
                        begin
                            q_pop      = 1'b1;
                            i_next     = '0;
                            j_next     = '0;
                            prev_next  = chain_seed;
                            mem_raddr  = CHECK_LO_IDX;
                            state_next = ST_BG_HI;
                        end
                        OP_DATA_CHAIN, OP_DATA_RC4:
                        begin
                            if (locked_reg)
                            begin
                                if (out_free)
                                begin
                                    q_pop         = 1'b1;
                                    m_tvalid_next = 1'b1;
                                    out_data_next = '0;
                                    out_rej_next  = 1'b1;
                                    out_last_next = q_item.final_req;
                                end
                            end
                            else if (q_item.op == OP_DATA_CHAIN)
                            begin
                                if (out_free)
                                begin
                                    q_pop         = 1'b1;
                                    prev_next     = q_item.data_word ^ prev_reg;
                                    m_tvalid_next = 1'b1;
                                    out_data_next = q_item.data_word ^ prev_reg;
                                    out_rej_next  = 1'b0;
                                    out_last_next = q_item.final_req;
                                end
                            end
                            else
                            begin
                                q_pop       = 1'b1;
                                i_next      = i_reg + IDX_W'(1);
                                mem_raddr   = i_reg + IDX_W'(1);
                                cipher_next = q_item.data_word[7:0];
                                fin_next    = q_item.final_req;
                                state_next  = ST_RD_J;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_J:
            begin
                // S[i] is in the read register; step j and fetch S[j].
                a_next     = rd_data_reg;
                j_next     = j_reg + rd_data_reg;
                mem_raddr  = j_reg + rd_data_reg;
                state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                // Write S[i] = S[j] and fetch the keystream entry.
                b_next     = rd_data_reg;
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = rd_data_reg;
                t_next     = a_reg + rd_data_reg;
                mem_raddr  = a_reg + rd_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Complete the swap and deliver the plaintext byte.
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = a_reg;
                mem_raddr = t_reg;
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {24'd0, cipher_reg ^ key_byte};
                    out_rej_next  = 1'b0;
                    out_last_next = fin_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_BG_HI:
            begin
                bad_lo_next = (rd_data_reg == BAD_MARK);
                mem_raddr   = CHECK_HI_IDX;
                state_next  = ST_BG_CHK;
            end
            ST_BG_CHK:
            begin
                if (bad_lo_reg && (rd_data_reg == BAD_MARK))
                begin
                    locked_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            prev_reg     <= '0;
            locked_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            prev_reg     <= prev_next;
            locked_reg   <= locked_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        bad_lo_reg   <= bad_lo_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        t_reg        <= t_next;
        cipher_reg   <= cipher_next;
        fin_reg      <= fin_next;
        out_data_reg <= out_data_next;
        out_rej_reg  <= out_rej_next;
        out_last_reg <= out_last_next;
    end

    // Permutation memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= perm_mem[mem_raddr];
    end

    `LSD_ASSERT_NEXT(a_lock_sticky, clk, rst_n, locked_reg, locked_reg)
    `LSD_ASSERT_NOW(a_pop_idle, clk, rst_n, q_pop, state_reg == ST_IDLE)
    `LSD_ASSERT_NOW(a_rej_zero, clk, rst_n, m_tvalid_reg && out_rej_reg, out_data_reg == '0)
    `LSD_ASSERT_NEXT(a_swap_order, clk, rst_n, state_reg == ST_RD_J, state_reg == ST_SWAP)

endmodule
